// ===== rtl/ir_remote_frame_transmitter_defines.svh =====
// assertion macros for the infrared frame transmitter
`ifndef IR_REMOTE_FRAME_TRANSMITTER_DEFINES_SVH
`define IR_REMOTE_FRAME_TRANSMITTER_DEFINES_SVH

// same-cycle implication
`define IRTX_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IRTX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/irtx_pkg.sv =====
package irtx_pkg;

  localparam int FRAME_BITS = 32;
  localparam int LATCH_BITS = 32;
  localparam int LATCH_W    = (FRAME_BITS > LATCH_BITS) ? FRAME_BITS : LATCH_BITS;
  localparam int IDX_W      = $clog2(FRAME_BITS);
  localparam int TICK_W     = 16;
  localparam int CFG_IDX_W  = 3;

  localparam logic [TICK_W-1:0] HEADER_MARK_RST  = TICK_W'(4500);
  localparam logic [TICK_W-1:0] HEADER_SPACE_RST = TICK_W'(4500);
  localparam logic [TICK_W-1:0] BIT_MARK_RST     = TICK_W'(560);
  localparam logic [TICK_W-1:0] ZERO_SPACE_RST   = TICK_W'(560);
  localparam logic [TICK_W-1:0] ONE_SPACE_RST    = TICK_W'(1690);
  localparam logic [TICK_W-1:0] GAP_RST          = TICK_W'(2500);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR_MARK,
    PH_HDR_SPACE,
    PH_BIT_MARK,
    PH_BIT_SPACE,
    PH_STOP_MARK,
    PH_GAP
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_MARK,
    REG_HEADER_SPACE,
    REG_BIT_MARK,
    REG_ZERO_SPACE,
    REG_ONE_SPACE,
    REG_GAP
  } cfg_reg_t;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

endpackage

// ===== rtl/irtx_req_if.sv =====
interface irtx_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] address;
  logic [7:0] command;

  modport source (output valid, output req_type, output address, output command, input ready);
  modport sink (input valid, input req_type, input address, input command, output ready);
endinterface

// ===== rtl/irtx_res_if.sv =====
interface irtx_res_if;
  logic valid;
  logic ready;
  logic mark;
  logic busy_res;
  logic frame_done;
  logic start_rejected;

  modport source (output valid, output mark, output busy_res, output frame_done,
                  output start_rejected, input ready);
  modport sink (input valid, input mark, input busy_res, input frame_done,
                input start_rejected, output ready);
endinterface

// ===== rtl/irtx_cfg_if.sv =====
interface irtx_cfg_if import irtx_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TICK_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ir_remote_frame_transmitter.sv =====
// infrared remote frame transmitter, one carrier level per microsecond tick
// item channel: req_type 0 is a tick, 1 is a start request with address and
// command; a start while idle latches the frame (address, address, command,
// inverted command, lsb first) and begins the header mark
// result channel: one transaction per item with mark, busy_res, frame_done
// and start_rejected; a start while a frame runs is ignored and flagged
// cfg channel: index 0..5 selects a duration register (header mark, header
// space, bit mark, zero space, one space, gap); other indices are dropped;
// always ready, write only while no item is outstanding
// the result of an item is valid in the cycle after its acceptance
// throughput: one item per cycle unless the result stalls; the phase counter,
// duration compare and phase step all settle between the state registers and
// the result register; a stalled result register holds; the item channel stays
// ready while the result register is empty or being taken in the same cycle
// reset: synchronous, returns to idle and loads the default durations
// (4500, 4500, 560, 560, 1690, 2500 ticks)
`include "ir_remote_frame_transmitter_defines.svh"

module ir_remote_frame_transmitter import irtx_pkg::*; (
  input logic          clk,
  input logic          rst,
  irtx_req_if.sink     item,
  irtx_res_if.source   result,
  irtx_cfg_if.sink     cfg
);

  logic [TICK_W-1:0] header_mark_ticks;
  logic [TICK_W-1:0] header_space_ticks;
  logic [TICK_W-1:0] bit_mark_ticks;
  logic [TICK_W-1:0] zero_space_ticks;
  logic [TICK_W-1:0] one_space_ticks;
  logic [TICK_W-1:0] gap_ticks;

  phase_t              phase, phase_next;
  logic [TICK_W-1:0]   tick_count, tick_count_next;
  logic [IDX_W-1:0]    bit_index, bit_index_next;
  logic [FRAME_BITS-1:0] frame_bits, frame_bits_next;

  logic [LATCH_BITS-1:0] frame_word;
  logic [LATCH_W-1:0]    frame_wide;
  logic [TICK_W-1:0]     dur, dur_eff;
  logic [TICK_W:0]       tick_inc;
  logic                  cur_bit;
  logic                  level;
  logic                  phase_end;
  logic                  mark_next, busy_next, done_next, rej_next;
  logic                  in_accept;

  assign in_accept  = item.valid && item.ready;
  assign item.ready = !result.valid || result.ready;
  assign cfg.ready  = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_mark_ticks  <= HEADER_MARK_RST;
      header_space_ticks <= HEADER_SPACE_RST;
      bit_mark_ticks     <= BIT_MARK_RST;
      zero_space_ticks   <= ZERO_SPACE_RST;
      one_space_ticks    <= ONE_SPACE_RST;
      gap_ticks          <= GAP_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_HEADER_MARK:  header_mark_ticks  <= cfg.data;
        REG_HEADER_SPACE: header_space_ticks <= cfg.data;
        REG_BIT_MARK:     bit_mark_ticks     <= cfg.data;
        REG_ZERO_SPACE:   zero_space_ticks   <= cfg.data;
        REG_ONE_SPACE:    one_space_ticks    <= cfg.data;
        REG_GAP:          gap_ticks          <= cfg.data;
        default: ;
      endcase
    end
  end

  assign frame_word = {~item.command, item.command, item.address, item.address};
  assign frame_wide = LATCH_W'(frame_word);
  assign cur_bit    = frame_bits[bit_index];
  assign level      = (phase == PH_HDR_MARK) || (phase == PH_BIT_MARK) ||
                      (phase == PH_STOP_MARK);

  always_comb begin
    unique case (phase)
      PH_HDR_MARK:  dur = header_mark_ticks;
      PH_HDR_SPACE: dur = header_space_ticks;
      PH_BIT_MARK:  dur = bit_mark_ticks;
      PH_BIT_SPACE: dur = cur_bit ? one_space_ticks : zero_space_ticks;
      PH_STOP_MARK: dur = bit_mark_ticks;
      PH_GAP:       dur = gap_ticks;
      default:      dur = TICK_W'(1);
    endcase
  end

  // a zero duration counts as one tick
  assign dur_eff   = (dur == '0) ? TICK_W'(1) : dur;
  assign tick_inc  = {1'b0, tick_count} + (TICK_W+1)'(1);
  assign phase_end = tick_inc >= {1'b0, dur_eff};

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    bit_index_next  = bit_index;
    frame_bits_next = frame_bits;
    mark_next       = 1'b0;
    busy_next       = 1'b0;
    done_next       = 1'b0;
    rej_next        = 1'b0;
    if (item.req_type == REQ_START) begin
      busy_next = 1'b1;
      if (phase == PH_IDLE) begin
        frame_bits_next = frame_wide[FRAME_BITS-1:0];
        phase_next      = PH_HDR_MARK;
        tick_count_next = '0;
        bit_index_next  = '0;
        mark_next       = 1'b1;
      end else begin
        rej_next  = 1'b1;
        mark_next = level;
      end
    end else if (phase != PH_IDLE) begin
      mark_next = level;
      busy_next = 1'b1;
      if (phase_end) begin
        tick_count_next = '0;
        unique case (phase)
          PH_HDR_MARK:  phase_next = PH_HDR_SPACE;
          PH_HDR_SPACE: begin
            phase_next     = PH_BIT_MARK;
            bit_index_next = '0;
          end
          PH_BIT_MARK:  phase_next = PH_BIT_SPACE;
          PH_BIT_SPACE: begin
            if (bit_index == IDX_W'(FRAME_BITS - 1)) begin
              phase_next = PH_STOP_MARK;
            end else begin
              bit_index_next = bit_index + IDX_W'(1);
              phase_next     = PH_BIT_MARK;
            end
          end
          PH_STOP_MARK: phase_next = PH_GAP;
          default: begin
            phase_next = PH_IDLE;
            done_next  = 1'b1;
          end
        endcase
      end else begin
        tick_count_next = tick_inc[TICK_W-1:0];
      end
    end else begin
      phase_next = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      bit_index  <= '0;
      frame_bits <= '0;
    end else if (in_accept) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      bit_index  <= bit_index_next;
      frame_bits <= frame_bits_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (in_accept) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      result.mark           <= mark_next;
      result.busy_res       <= busy_next;
      result.frame_done     <= done_next;
      result.start_rejected <= rej_next;
    end
  end

  `IRTX_ASSERT_NOW(a_done_in_gap, clk, rst, result.valid && result.frame_done,
    result.busy_res && !result.mark && !result.start_rejected, "frame end out of gap")
  `IRTX_ASSERT_NOW(a_reject_busy, clk, rst, result.valid && result.start_rejected,
    result.busy_res && !result.frame_done, "rejected start without busy frame")
  `IRTX_ASSERT_NEXT(a_start_hdr, clk, rst,
    in_accept && item.req_type == REQ_START && phase == PH_IDLE,
    phase == PH_HDR_MARK && tick_count == '0 && result.mark, "start did not open header")
  `IRTX_ASSERT_NEXT(a_idle_tick, clk, rst,
    in_accept && item.req_type == REQ_TICK && phase == PH_IDLE,
    phase == PH_IDLE && !result.busy_res, "idle tick left idle")

endmodule

// ===== tb/tb_ir_remote_frame_transmitter.sv =====
module tb_ir_remote_frame_transmitter;
  import irtx_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 100_000;
  localparam int RANDOM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 108;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic mark;
    logic busy_res;
    logic frame_done;
    logic start_rejected;
  } ir_out_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic                  req_type;
    logic [7:0]            address;
    logic [7:0]            command;
    logic [CFG_IDX_W-1:0]  index;
    logic [TICK_W-1:0]     data;
    bit                    typed;
    ir_out_t               want;
  } stim_row_t;

  // want is mark, busy_res, frame_done, start_rejected
  stim_row_t opening_rows [$] = '{
    '{ROW_ITEM, REQ_TICK,  8'h00, 8'h00, '0, '0, 1'b1, 4'b0000},
    '{ROW_CFG,  REQ_TICK,  8'h00, 8'h00, REG_GAP, 16'h0000, 1'b0, 4'b0000},
    '{ROW_CFG,  REQ_TICK,  8'h00, 8'h00, REG_SPARE_LO, 16'hFFFF, 1'b0, 4'b0000},
    '{ROW_CFG,  REQ_TICK,  8'h00, 8'h00, REG_SPARE_HI, 16'h0000, 1'b0, 4'b0000},
    '{ROW_ITEM, REQ_START, 8'h00, 8'h00, '0, '0, 1'b1, 4'b1100},
    '{ROW_ITEM, REQ_START, 8'hFF, 8'hFF, '0, '0, 1'b1, 4'b1101},
    '{ROW_ITEM, REQ_TICK,  8'h00, 8'h00, '0, '0, 1'b1, 4'b1100},
    '{ROW_CFG,  REQ_TICK,  8'h00, 8'h00, REG_HEADER_MARK, 16'h0001, 1'b0, 4'b0000},
    '{ROW_ITEM, REQ_TICK,  8'hFF, 8'hFF, '0, '0, 1'b1, 4'b1100},
    '{ROW_ITEM, REQ_TICK,  8'h00, 8'h00, '0, '0, 1'b1, 4'b0100},
    '{ROW_ITEM, REQ_START, 8'h5A, 8'hA5, '0, '0, 1'b1, 4'b0101},
    '{ROW_CFG,  REQ_TICK,  8'h00, 8'h00, REG_HEADER_SPACE, 16'hFFFF, 1'b0, 4'b0000},
    '{ROW_ITEM, REQ_TICK,  8'h00, 8'h00, '0, '0, 1'b0, 4'b0000},
    '{ROW_CFG,  REQ_TICK,  8'h00, 8'h00, REG_HEADER_SPACE, 16'h0001, 1'b0, 4'b0000},
    '{ROW_CFG,  REQ_TICK,  8'h00, 8'h00, REG_BIT_MARK, 16'h0001, 1'b0, 4'b0000},
    '{ROW_CFG,  REQ_TICK,  8'h00, 8'h00, REG_ZERO_SPACE, 16'h0001, 1'b0, 4'b0000},
    '{ROW_CFG,  REQ_TICK,  8'h00, 8'h00, REG_ONE_SPACE, 16'h0002, 1'b0, 4'b0000},
    '{ROW_ITEM, REQ_TICK,  8'h00, 8'h00, '0, '0, 1'b0, 4'b0000},
    '{ROW_ITEM, REQ_TICK,  8'h00, 8'h00, '0, '0, 1'b0, 4'b0000},
    '{ROW_ITEM, REQ_START, 8'h00, 8'hFF, '0, '0, 1'b0, 4'b0000},
    '{ROW_ITEM, REQ_TICK,  8'h00, 8'h00, '0, '0, 1'b0, 4'b0000},
    '{ROW_ITEM, REQ_TICK,  8'h00, 8'h00, '0, '0, 1'b0, 4'b0000},
    '{ROW_ITEM, REQ_TICK,  8'h00, 8'h00, '0, '0, 1'b0, 4'b0000},
    '{ROW_ITEM, REQ_TICK,  8'h00, 8'h00, '0, '0, 1'b0, 4'b0000},
    '{ROW_ITEM, REQ_TICK,  8'h00, 8'h00, '0, '0, 1'b0, 4'b0000},
    '{ROW_ITEM, REQ_TICK,  8'h00, 8'h00, '0, '0, 1'b0, 4'b0000}
  };

  logic clk;
  logic rst;

  irtx_req_if item_ch();
  irtx_res_if result_ch();
  irtx_cfg_if cfg_ch();

  ir_remote_frame_transmitter uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // frame state as the transmitter should hold it
  phase_t            ph;
  logic [TICK_W-1:0] ticks_in_phase;
  logic [5:0]        bit_pos;
  logic [31:0]       frame_word;
  logic [TICK_W-1:0] tick_len [6];

  ir_out_t frame_levels [$];
  int      errors = 0;
  int      results_seen = 0;
  int      cycles = 0;
  int      idle_send_pct;
  int      idle_recv_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, frame_levels.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic carrier_on();
    return ph == PH_HDR_MARK || ph == PH_BIT_MARK || ph == PH_STOP_MARK;
  endfunction

  function automatic logic [TICK_W-1:0] phase_len();
    logic [TICK_W-1:0] d;
    case (ph)
      PH_HDR_MARK:  d = tick_len[REG_HEADER_MARK];
      PH_HDR_SPACE: d = tick_len[REG_HEADER_SPACE];
      PH_BIT_MARK:  d = tick_len[REG_BIT_MARK];
      PH_BIT_SPACE: d = frame_word[bit_pos[4:0]] ? tick_len[REG_ONE_SPACE]
                                                 : tick_len[REG_ZERO_SPACE];
      PH_STOP_MARK: d = tick_len[REG_BIT_MARK];
      PH_GAP:       d = tick_len[REG_GAP];
      default:      d = 16'd1;
    endcase
    return (d == 16'd0) ? 16'd1 : d;
  endfunction

  function automatic ir_out_t advance_frame(input logic rt, input logic [7:0] a,
                                            input logic [7:0] c);
    ir_out_t r;
    r = '0;
    if (rt == REQ_START) begin
      if (ph == PH_IDLE) begin
        frame_word = {~c, c, a, a};
        ph = PH_HDR_MARK;
        ticks_in_phase = '0;
        bit_pos = '0;
      end else begin
        r.start_rejected = 1'b1;
      end
      r.mark = carrier_on();
      r.busy_res = 1'b1;
    end else if (ph != PH_IDLE) begin
      r.mark = carrier_on();
      r.busy_res = 1'b1;
      if (32'(ticks_in_phase) + 1 >= 32'(phase_len())) begin
        ticks_in_phase = '0;
        case (ph)
          PH_HDR_MARK:  ph = PH_HDR_SPACE;
          PH_HDR_SPACE: begin
            ph = PH_BIT_MARK;
            bit_pos = '0;
          end
          PH_BIT_MARK:  ph = PH_BIT_SPACE;
          PH_BIT_SPACE: begin
            if (bit_pos == 6'(FRAME_BITS - 1)) begin
              ph = PH_STOP_MARK;
            end else begin
              bit_pos = bit_pos + 6'd1;
              ph = PH_BIT_MARK;
            end
          end
          PH_STOP_MARK: ph = PH_GAP;
          default: begin
            ph = PH_IDLE;
            r.frame_done = 1'b1;
          end
        endcase
      end else begin
        ticks_in_phase = ticks_in_phase + 16'd1;
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task automatic send_item(input logic rt, input logic [7:0] a, input logic [7:0] c,
                           input bit typed, input ir_out_t given);
    ir_out_t out;
    while ($urandom_range(99) < idle_send_pct) begin
      item_ch.valid <= 1'b0;
      item_ch.address <= 8'($urandom);
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.req_type <= rt;
    item_ch.address <= a;
    item_ch.command <= c;
    do @(posedge clk); while (!item_ch.ready);
    out = advance_frame(rt, a, c);
    frame_levels.push_back(typed ? given : out);
  endtask

  // leaves the item channel quiet until every result is back
  task automatic hold_until_drained();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (frame_levels.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx <= REG_GAP) tick_len[idx] = val;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // result side: random back-pressure and in-order compare
  initial begin
    ir_out_t got;
    ir_out_t want;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        got = '{result_ch.mark, result_ch.busy_res, result_ch.frame_done,
                result_ch.start_rejected};
        if (frame_levels.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with nothing outstanding", results_seen));
        end else begin
          want = frame_levels.pop_front();
          if (got !== want)
            flag_mismatch($sformatf(
              "result %0d mark %b/%b busy_res %b/%b frame_done %b/%b start_rejected %b/%b",
              results_seen, got.mark, want.mark, got.busy_res, want.busy_res,
              got.frame_done, want.frame_done, got.start_rejected, want.start_rejected));
        end
        results_seen++;
      end
      result_ch.ready <= ($urandom_range(99) >= idle_recv_pct);
    end
  end

  initial begin
    int style;
    logic rt;
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.req_type <= REQ_TICK;
    item_ch.address <= '0;
    item_ch.command <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    ph = PH_IDLE;
    ticks_in_phase = '0;
    bit_pos = '0;
    frame_word = '0;
    tick_len[REG_HEADER_MARK] = HEADER_MARK_RST;
    tick_len[REG_HEADER_SPACE] = HEADER_SPACE_RST;
    tick_len[REG_BIT_MARK] = BIT_MARK_RST;
    tick_len[REG_ZERO_SPACE] = ZERO_SPACE_RST;
    tick_len[REG_ONE_SPACE] = ONE_SPACE_RST;
    tick_len[REG_GAP] = GAP_RST;
    idle_send_pct = 23;
    idle_recv_pct = 63;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_rows[i]) begin
      if (opening_rows[i].kind == ROW_CFG) begin
        hold_until_drained();
        write_reg(opening_rows[i].index, opening_rows[i].data);
      end else begin
        send_item(opening_rows[i].req_type, opening_rows[i].address, opening_rows[i].command,
                  opening_rows[i].typed, opening_rows[i].want);
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p / 4)
        0: begin
          idle_send_pct = 23;
          idle_recv_pct = 63;
        end
        1: begin
          idle_send_pct = 63;
          idle_recv_pct = 23;
        end
        default: begin
          idle_send_pct = 0;
          idle_recv_pct = 0;
        end
      endcase
      hold_until_drained();
      // a full-range value first, then the working durations over it
      write_reg(CFG_IDX_W'($urandom_range(7)), TICK_W'($urandom));
      style = p % 4;
      for (int r = REG_HEADER_MARK; r <= REG_GAP; r++) begin
        case (style)
          0: write_reg(CFG_IDX_W'(r), 16'd1);
          1: write_reg(CFG_IDX_W'(r), TICK_W'($urandom_range(3)));
          2: write_reg(CFG_IDX_W'(r), TICK_W'($urandom_range(1, 2)));
          default: write_reg(CFG_IDX_W'(r), 16'd0);
        endcase
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(59) == 0) hold_until_drained();
        rt = ($urandom_range(99) < 6) ? REQ_START : REQ_TICK;
        send_item(rt, 8'($urandom), 8'($urandom), 1'b0, '0);
      end
    end

    // longest header mark, then cut short by a rewrite
    hold_until_drained();
    for (int r = REG_HEADER_SPACE; r <= REG_GAP; r++) write_reg(CFG_IDX_W'(r), 16'd1);
    write_reg(REG_HEADER_MARK, 16'd1);
    while (ph != PH_IDLE) send_item(REQ_TICK, 8'h00, 8'h00, 1'b0, '0);
    hold_until_drained();
    write_reg(REG_HEADER_MARK, 16'hFFFF);
    send_item(REQ_START, 8'hFF, 8'h00, 1'b0, '0);
    repeat (16) send_item(REQ_TICK, 8'h00, 8'h00, 1'b0, '0);
    hold_until_drained();
    write_reg(REG_HEADER_MARK, 16'd1);
    while (ph != PH_IDLE) send_item(REQ_TICK, 8'h00, 8'h00, 1'b0, '0);

    hold_until_drained();
    repeat (20) @(posedge clk);
    if (frame_levels.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", frame_levels.size()));
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/irtx_pkg.sv
rtl/irtx_req_if.sv
rtl/irtx_res_if.sv
rtl/irtx_cfg_if.sv
rtl/ir_remote_frame_transmitter.sv
tb/tb_ir_remote_frame_transmitter.sv
